/* rtl/core/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scan unit.
// No dependencies; used by every module under rtl/core.
package wbps_pkg;

	// Pattern storage is fixed by the register map: sixteen bytes at most.
	localparam int PAT_BYTES = 16;
	localparam int PAT_IDX_W = 4;
	localparam int LEN_W     = 5;
	localparam int OFF_W     = 32;

	// Configuration port geometry: 64-bit registers at 8-byte spacing.
	localparam int APB_DW = 64;
	localparam int APB_AW = 5;
	localparam int REG_W  = 2;

	localparam logic [REG_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [REG_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [REG_W-1:0] REG_WILD     = 2'd2;
	localparam logic [REG_W-1:0] REG_LEN      = 2'd3;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

	// Pattern settings as seen by the compare cells.
	typedef struct packed {
		logic [8*PAT_BYTES-1:0] pattern;
		logic [PAT_BYTES-1:0]   wild;
		logic [LEN_W-1:0]       len;     // clamped to 1..PATTERN_MAX
	} scan_cfg_t;

endpackage

/* rtl/core/wbps_cfg_regs.sv */
// Configuration register file with APB-style access for the pattern scan unit.
// Depends on wbps_pkg.
module wbps_cfg_regs #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wbps_pkg::APB_AW-1:0] paddr,
	input  logic [wbps_pkg::APB_DW-1:0] pwdata,
	output logic [wbps_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output wbps_pkg::scan_cfg_t        cfg
);

	localparam logic [wbps_pkg::LEN_W-1:0] LEN_MAX = wbps_pkg::LEN_W'(PATTERN_MAX);

	logic [63:0]                  pat_low_q;
	logic [63:0]                  pat_high_q;
	logic [15:0]                  wild_q;
	logic [wbps_pkg::LEN_W-1:0]   len_q;
	logic [wbps_pkg::REG_W-1:0]   reg_sel;
	logic                         wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[wbps_pkg::APB_AW-1:3];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			wild_q     <= '0;
			len_q      <= wbps_pkg::LEN_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				wbps_pkg::REG_PAT_LOW:  pat_low_q  <= pwdata;
				wbps_pkg::REG_PAT_HIGH: pat_high_q <= pwdata;
				wbps_pkg::REG_WILD:     wild_q     <= pwdata[15:0];
				wbps_pkg::REG_LEN:      len_q      <= pwdata[wbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			wbps_pkg::REG_PAT_LOW:  prdata = pat_low_q;
			wbps_pkg::REG_PAT_HIGH: prdata = pat_high_q;
			wbps_pkg::REG_WILD:     prdata = {48'b0, wild_q};
			wbps_pkg::REG_LEN:      prdata = {{(wbps_pkg::APB_DW-wbps_pkg::LEN_W){1'b0}}, len_q};
			default:                prdata = '0;
		endcase
	end

	// Clamp the length: zero acts as one, anything above the cell count as the cell count.
	always_comb begin
		cfg.pattern = {pat_high_q, pat_low_q};
		cfg.wild    = wild_q;
		if (len_q == '0)
			cfg.len = wbps_pkg::LEN_RESET;
		else if (len_q > LEN_MAX)
			cfg.len = LEN_MAX;
		else
			cfg.len = len_q;
	end

endmodule

/* rtl/core/wbps_cell.sv */
// One window cell: compares the byte reaching it against its pattern byte and holds it
// for the next cell. Depends on wbps_pkg.
module wbps_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                shift_en,
	input  logic [7:0]          byte_in,
	input  wbps_pkg::scan_cfg_t cfg,
	output logic [7:0]          byte_out,
	output logic                hit
);

	logic [7:0]                     byte_q;
	logic [wbps_pkg::LEN_W-1:0]     pos;
	logic [wbps_pkg::PAT_IDX_W-1:0] sel;
	logic [7:0]                     pat;
	logic                           active;

	always_ff @(posedge clk) begin
		if (shift_en)
			byte_q <= byte_in;
	end

	assign byte_out = byte_q;

	// Window position IDX lines up with pattern byte len-1-IDX.
	assign active = wbps_pkg::LEN_W'(IDX) < cfg.len;
	assign pos    = cfg.len - wbps_pkg::LEN_W'(IDX + 1);
	assign sel    = pos[wbps_pkg::PAT_IDX_W-1:0];
	assign pat    = cfg.pattern[sel*8 +: 8];
	assign hit    = !active || cfg.wild[sel] || (byte_in == pat);

endmodule

/* rtl/core/wildcard_byte_pattern_scan_unit.sv */
// Wildcard byte pattern scan unit: top level. A result word is registered and offered
// in the cycle after the byte that causes it. Throughput: one byte per cycle while s_tready
// is high. The window's cell chain shifts on each accepted byte but a region's last. Reset
// (arst_n low): registers return to defaults, the window count and found flag clear, and
// no result is pending. Depends on wbps_pkg, wbps_cfg_regs and wbps_cell.
module wildcard_byte_pattern_scan_unit #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte stream in
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tlast,   // region_end
	// result words out
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // [31:0] match_offset
	output logic                        m_tuser,   // found
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbps_pkg::APB_AW-1:0] paddr,
	input  logic [wbps_pkg::APB_DW-1:0] pwdata,
	output logic [wbps_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	wbps_pkg::scan_cfg_t       cfg;
	logic [7:0]                chain [PATTERN_MAX+1];
	logic [PATTERN_MAX-1:0]    hits;
	logic [OFFSET_BITS-1:0]    count_q;
	logic                      found_q;
	logic                      out_valid_q;
	logic                      out_found_q;
	logic [31:0]               out_offset_q;
	logic                      take;
	logic                      shift_en;
	logic [wbps_pkg::LEN_W-1:0] len_m1;
	logic [OFFSET_BITS-1:0]    len_m1_ext;
	logic                      count_ok;
	logic                      match;
	logic                      report_hit;
	logic                      report_miss;
	logic [OFFSET_BITS-1:0]    start_off;
	logic [OFFSET_BITS+31:0]   start_wide;

	wbps_cfg_regs #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept a byte whenever the output slot is empty or being drained this cycle.
	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	// Advance the window on every byte except the last of a region.
	assign shift_en = take && !s_tlast;

	// Cell 0 sees the incoming byte, cell i sees the byte i places back.
	assign chain[0] = s_tdata;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wbps_cell #(
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.byte_in  (chain[i]),
			.cfg      (cfg),
			.byte_out (chain[i+1]),
			.hit      (hits[i])
		);
	end

	// The window is only meaningful once len-1 bytes of this region have gone by;
	// stale bytes from earlier regions sit beyond that point.
	assign len_m1      = cfg.len - wbps_pkg::LEN_W'(1);
	assign len_m1_ext  = {{(OFFSET_BITS-wbps_pkg::LEN_W){1'b0}}, len_m1};
	assign count_ok    = count_q >= len_m1_ext;
	assign match       = count_ok && (&hits);
	assign report_hit  = !found_q && match;
	assign report_miss = !found_q && !match && s_tlast;
	assign start_off   = count_q - len_m1_ext;
	assign start_wide  = {32'b0, start_off};

	// Region state: saturating byte counter and the found flag; clear both at region end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (take) begin
			if (s_tlast) begin
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (count_q != COUNT_MAX)
					count_q <= count_q + OFFSET_BITS'(1);
				if (match)
					found_q <= 1'b1;
			end
		end
	end

	// Output register: load a new result word, or drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && (report_hit || report_miss)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (report_hit || report_miss)) begin
			out_found_q  <= report_hit;
			out_offset_q <= report_hit ? start_wide[31:0] : 32'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_offset_q;

endmodule
